FILE: hw/rtl/knpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knpm_pkg
// Shared types and codes for the k-nearest point mixer.
// ----------------------------------------------------------------------------
package knpm_pkg;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam int unsigned ROOT_W = 17;
    localparam int unsigned DIST_W = 33;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic [3:0]  neighbor_count;
    } t_in;

    typedef struct packed {
        logic [9:0]  neighbor_index;
        logic [32:0] square_distance;
        logic [15:0] volume;
        logic [1:0]  status;
        logic        last;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic emit_single;
        logic root_start;
        logic div_start;
        logic emit_list;
        logic j_step;
        logic j_reset;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic scan_done;
        logic busy;
        logic j_last;
    } t_stat;

endpackage

FILE: hw/rtl/knpm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knpm_ctrl
// Sequencer: accept, scan, square roots, divides and result transfers.
// ----------------------------------------------------------------------------
module knpm_ctrl
    import knpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_kind,
    output logic       o_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_SCAN,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_DIV_GO,
        S_DIV_WAIT
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_kind)
                        KIND_LOAD:  n_state = S_RESP;
                        KIND_CLEAR: n_state = S_RESP;
                        KIND_QUERY: n_state = i_stat.count_zero ? S_RESP : S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.j_reset = 1'b1;
                    n_state = S_ROOT_GO;
                end
            end
            S_ROOT_GO: begin
                o_cmd.root_start = 1'b1;
                n_state = S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
                if (!i_stat.busy) begin
                    if (i_stat.j_last) begin
                        o_cmd.j_reset = 1'b1;
                        n_state = S_DIV_GO;
                    end else begin
                        o_cmd.j_step = 1'b1;
                        n_state = S_ROOT_GO;
                    end
                end
            end
            S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (!i_stat.busy && i_stat.out_free) begin
                    o_cmd.emit_list = 1'b1;
                    if (i_stat.j_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.j_step = 1'b1;
                        n_state = S_DIV_GO;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/knpm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knpm_dp
// Datapath: point memory, distance pipeline, sorted neighbor list,
// bit-serial square root and divider, output register.
// ----------------------------------------------------------------------------
module knpm_dp
    import knpm_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_data,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_valid,
    input  logic  i_ready,
    output t_out  o_data
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int KW    = $clog2(MAX_NEIGHBORS + 1);
    localparam int JW    = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int SUM_W = ROOT_W + KW;
    localparam int DIV_N = 32;

    // point memory
    logic [31:0] mem [MAX_POINTS];
    logic [31:0] r_rdata;

    logic [CW-1:0] r_count;
    logic [15:0]   r_qx, r_qy;
    logic [KW-1:0] r_k;
    t_out          r_single;
    t_out          n_single;

    // scan pipeline
    logic          r_scan_act;
    logic [CW-1:0] r_scan_i;
    logic          r_p1_vld, r_p2_vld;
    logic [AW-1:0] r_p1_idx, r_p2_idx;
    logic [31:0]   r_sqx, r_sqy;

    // neighbor list
    logic [DIST_W-1:0] r_bd    [MAX_NEIGHBORS];
    logic [AW-1:0]     r_bi    [MAX_NEIGHBORS];
    logic [ROOT_W-1:0] r_roots [MAX_NEIGHBORS];
    logic [KW-1:0]     r_filled;
    logic [JW-1:0]     r_j;
    logic [SUM_W-1:0]  r_sum;

    // iterative units
    logic              r_busy;
    logic              r_is_div;
    logic [5:0]        r_cnt;
    logic [33:0]       r_sqv;
    logic [18:0]       r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [31:0]       r_dn;
    logic [SUM_W:0]    r_drem;
    logic [15:0]       r_dq;

    logic r_out_vld;
    t_out r_out;

    // input decode
    logic [KW-1:0] k_clamped;
    always_comb begin
        if (i_data.neighbor_count == 4'd0) begin
            k_clamped = KW'(1);
        end else if (32'(i_data.neighbor_count) > MAX_NEIGHBORS) begin
            k_clamped = KW'(MAX_NEIGHBORS);
        end else begin
            k_clamped = KW'(i_data.neighbor_count);
        end
    end

    logic is_full;
    assign is_full = (32'(r_count) >= MAX_POINTS);

    logic do_load, do_query, do_clear;
    assign do_load  = i_cmd.capture && (i_data.kind == KIND_LOAD);
    assign do_query = i_cmd.capture && (i_data.kind == KIND_QUERY);
    assign do_clear = i_cmd.capture && (i_data.kind == KIND_CLEAR);

    // single-result transfer for load, clear and empty query
    always_comb begin
        n_single      = '0;
        n_single.last = 1'b1;
        if (i_data.kind == KIND_LOAD) begin
            if (is_full) begin
                n_single.status = ST_FULL;
            end else begin
                n_single.neighbor_index = 10'(32'(r_count));
            end
        end else if (i_data.kind == KIND_QUERY && r_count == '0) begin
            n_single.status = ST_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load && !is_full) begin
            mem[r_count[AW-1:0]] <= {i_data.point_x, i_data.point_y};
        end
        if (r_scan_act) begin
            r_rdata <= mem[r_scan_i[AW-1:0]];
        end
    end

    // distance stage
    logic [15:0] dx, dy;
    assign dx = (r_qx >= r_rdata[31:16]) ? (r_qx - r_rdata[31:16]) : (r_rdata[31:16] - r_qx);
    assign dy = (r_qy >= r_rdata[15:0])  ? (r_qy - r_rdata[15:0])  : (r_rdata[15:0] - r_qy);

    // sorted insert: ins[j] marks slots that take a new or shifted entry
    logic [DIST_W-1:0]  d_new;
    logic [MAX_NEIGHBORS-1:0] ins;
    assign d_new = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_comb begin
        for (int j = 0; j < MAX_NEIGHBORS; j++) begin
            if (32'(j) >= 32'(r_k)) begin
                ins[j] = 1'b0;
            end else if (32'(j) < 32'(r_filled)) begin
                ins[j] = (d_new < r_bd[j]);
            end else begin
                ins[j] = (32'(j) == 32'(r_filled));
            end
        end
    end

    // square root step
    logic [18:0] sq_rem2, sq_trial;
    assign sq_rem2  = {r_rem[16:0], r_sqv[33:32]};
    assign sq_trial = {r_root, 2'b01};

    // divide step
    logic [SUM_W:0] dv_rem2;
    assign dv_rem2 = {r_drem[SUM_W-1:0], r_dn[31]};

    logic out_free;
    assign out_free = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_scan_act <= 1'b0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_busy     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            // capture
            if (i_cmd.capture) begin
                r_qx     <= i_data.point_x;
                r_qy     <= i_data.point_y;
                r_k      <= k_clamped;
                r_single <= n_single;
            end
            if (do_load && !is_full) begin
                r_count <= r_count + 1'b1;
            end
            if (do_clear) begin
                r_count <= '0;
            end
            if (do_query && r_count != '0) begin
                r_scan_act <= 1'b1;
                r_scan_i   <= '0;
                r_filled   <= '0;
                r_sum      <= '0;
            end

            // scan address stage
            r_p1_vld <= r_scan_act;
            if (r_scan_act) begin
                r_p1_idx <= r_scan_i[AW-1:0];
                r_scan_i <= r_scan_i + 1'b1;
                if (r_scan_i == r_count - 1'b1) begin
                    r_scan_act <= 1'b0;
                end
            end
            // square stage
            r_p2_vld <= r_p1_vld;
            if (r_p1_vld) begin
                r_sqx    <= dx * dx;
                r_sqy    <= dy * dy;
                r_p2_idx <= r_p1_idx;
            end
            // insert stage
            if (r_p2_vld) begin
                for (int j = 0; j < MAX_NEIGHBORS; j++) begin
                    if (ins[j]) begin
                        if (j > 0 && ins[(j > 0) ? j - 1 : 0]) begin
                            r_bd[j] <= r_bd[(j > 0) ? j - 1 : 0];
                            r_bi[j] <= r_bi[(j > 0) ? j - 1 : 0];
                        end else begin
                            r_bd[j] <= d_new;
                            r_bi[j] <= r_p2_idx;
                        end
                    end
                end
                if (r_filled < r_k) begin
                    r_filled <= r_filled + 1'b1;
                end
            end

            // list index
            if (i_cmd.j_reset) begin
                r_j <= '0;
            end else if (i_cmd.j_step) begin
                r_j <= r_j + 1'b1;
            end

            // iterative units
            if (i_cmd.root_start) begin
                r_busy   <= 1'b1;
                r_is_div <= 1'b0;
                r_cnt    <= 6'd17;
                r_sqv    <= {1'b0, r_bd[r_j]};
                r_rem    <= '0;
                r_root   <= '0;
            end else if (i_cmd.div_start) begin
                r_is_div <= 1'b1;
                r_drem   <= '0;
                r_dq     <= '0;
                r_dn     <= {r_roots[r_j], 15'd0};
                r_cnt    <= 6'(DIV_N);
                r_busy   <= (r_sum != '0);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (!r_is_div) begin
                    r_sqv <= {r_sqv[31:0], 2'b00};
                    if (sq_rem2 >= sq_trial) begin
                        r_rem  <= sq_rem2 - sq_trial;
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem2;
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    if (r_cnt == 6'd1) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_dn <= {r_dn[30:0], 1'b0};
                    if (dv_rem2 >= {1'b0, r_sum}) begin
                        r_drem <= dv_rem2 - {1'b0, r_sum};
                        r_dq   <= {r_dq[14:0], 1'b1};
                    end else begin
                        r_drem <= dv_rem2;
                        r_dq   <= {r_dq[14:0], 1'b0};
                    end
                    if (r_cnt == 6'd1) begin
                        r_busy <= 1'b0;
                    end
                end
            end
            // store finished root
            if (r_busy && !r_is_div && r_cnt == 6'd1) begin
                r_roots[r_j] <= (sq_rem2 >= sq_trial) ? {r_root[ROOT_W-2:0], 1'b1}
                                                      : {r_root[ROOT_W-2:0], 1'b0};
                r_sum <= r_sum + SUM_W'((sq_rem2 >= sq_trial) ?
                         {r_root[ROOT_W-2:0], 1'b1} : {r_root[ROOT_W-2:0], 1'b0});
            end

            // output register
            if (i_cmd.emit_single) begin
                r_out_vld <= 1'b1;
                r_out     <= r_single;
            end else if (i_cmd.emit_list) begin
                r_out_vld                <= 1'b1;
                r_out.neighbor_index     <= 10'(32'(r_bi[r_j]));
                r_out.square_distance    <= r_bd[r_j];
                r_out.volume             <= (r_sum == '0) ? 16'd0 : r_dq;
                r_out.status             <= (r_filled < r_k) ? ST_SHORT : ST_OK;
                r_out.last               <= (32'(r_j) + 1 == 32'(r_filled));
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_stat.out_free   = out_free;
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.scan_done  = !r_scan_act && !r_p1_vld && !r_p2_vld;
    assign o_stat.busy       = r_busy;
    assign o_stat.j_last     = (32'(r_j) + 1 == 32'(r_filled));

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

FILE: hw/rtl/k_nearest_point_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_point_mixer
// Point store with k-nearest-neighbor query and mixing volumes.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_data): load a point, clear the store, or
// query the k nearest stored points. One item is worked on at a time; o_ready
// is high only while the sequencer is idle.
// Output channel (o_valid/i_ready, o_data): one transfer per load or clear
// (acknowledge, status full if the store was full), one per empty query, and
// otherwise one per neighbor, nearest first, last set on the final one.
// Load/clear: the result passes the response state to the output register.
// Query with N stored points and k neighbors: a scan of the N points (one
// memory read per cycle through a 3-stage distance pipeline), then one square
// root per listed neighbor, then one divide and result per listed neighbor.
// A stalled receiver holds the result in the output register and the
// sequencer waits before issuing the next one.
// Reset clears the point count, the sequencer and the output valid; the
// point memory itself is not cleared.
// ----------------------------------------------------------------------------
module k_nearest_point_mixer
    import knpm_pkg::*;
#(
    parameter int MAX_POINTS    = 1024,
    parameter int MAX_NEIGHBORS = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_cmd  cmd;
    t_stat stat;

    knpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_data.kind),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    knpm_dp #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_NEIGHBORS (MAX_NEIGHBORS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
